FILE: sv/distance_vector_route_update_core_macros.svh
// Assertion macros for the distance vector route update core.
// Used by the port checker; needs clk_i and rst_ni in the including scope.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DVRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dvru assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DVRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dvru assertion failed");

`endif

FILE: sv/dvru_pkg.sv
// Package of the distance vector route update core.
// Holds the command and configuration types used by the front, back end and top.
`default_nettype none

package dvru_pkg;

  localparam int unsigned NodeW = 3;
  localparam int unsigned CostW = 16;
  localparam int unsigned CmdFifoDepth = 2;

  // Register indexes on the configuration port.
  localparam logic RegSelfId = 1'b0;
  localparam logic RegUnreach = 1'b1;

  // Input selector values.
  localparam logic ModeJoin = 1'b0;
  localparam logic ModeUpdate = 1'b1;

  // What the back end does with one entry.
  typedef enum logic [1:0] {
    OP_SKIP  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RELAX = 2'd2
  } op_e;

  typedef struct packed {
    logic             mode;
    op_e              op;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] entry;
    logic [CostW-1:0] cost;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [NodeW-1:0] self_id;
    logic [CostW-1:0] unreachable_cost;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/dvru_front.sv
// Front end: accepts input beats and classifies them into commands.
// Depends on dvru_pkg; feeds dvru_cmd_fifo.
`default_nettype none

module dvru_front #(
  parameter int NODE_COUNT = 8
) (
  input  wire dvru_pkg::cfg_t cfg_i,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: source_node[2:0], entry_index[5:3], cost_value[21:6], zero pad
  input  wire logic [23:0]    s_axis_tdata,
  // tuser: mode
  input  wire logic           s_axis_tuser,
  input  wire logic           s_axis_tlast,
  input  wire logic           fifo_full_i,
  output logic                push_o,
  output dvru_pkg::cmd_t      cmd_o
);
  import dvru_pkg::*;

  localparam logic [NodeW:0] NodeCnt = (NodeW + 1)'(NODE_COUNT);

  logic [NodeW-1:0] src;
  logic [NodeW-1:0] entry;
  logic [CostW-1:0] cost;
  logic             entry_ok;
  logic             src_ok;

  assign src   = s_axis_tdata[2:0];
  assign entry = s_axis_tdata[5:3];
  assign cost  = s_axis_tdata[21:6];

  // Range checks against the node count.
  assign entry_ok = {1'b0, entry} < NodeCnt;
  assign src_ok   = {1'b0, src} < NodeCnt;

  // The queue takes a beat whenever it has room.
  assign s_axis_tready = !fifo_full_i;
  assign push_o        = s_axis_tvalid && !fifo_full_i;

  // Classify the entry; the self entry and unreachable costs are never relaxed.
  always_comb begin
    cmd_o.mode  = s_axis_tuser;
    cmd_o.src   = src;
    cmd_o.entry = entry;
    cmd_o.cost  = cost;
    cmd_o.last  = s_axis_tlast;
    cmd_o.op    = OP_SKIP;
    if (s_axis_tuser == ModeJoin) begin
      if (entry_ok) begin
        cmd_o.op = OP_LOAD;
      end
    end else if (entry_ok && src_ok && (entry != cfg_i.self_id) &&
                 (cost < cfg_i.unreachable_cost)) begin
      cmd_o.op = OP_RELAX;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dvru_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on dvru_pkg for the command type and depth.
`default_nettype none

module dvru_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dvru_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output dvru_pkg::cmd_t      cmd_o,
  output logic                valid_o,
  output logic                full_o
);
  import dvru_pkg::*;

  localparam int unsigned PtrW = (CmdFifoDepth > 1) ? $clog2(CmdFifoDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdFifoDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CmdFifoDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CmdFifoDepth);

  cmd_t            slot_q [CmdFifoDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == FullCnt;
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dvru_back.sv
// Back end: holds the cost tables, relaxes entries and runs vector broadcasts.
// Depends on dvru_pkg; takes commands from dvru_cmd_fifo.
`default_nettype none

module dvru_back #(
  parameter int NODE_COUNT = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dvru_pkg::cfg_t              cfg_i,
  input  wire dvru_pkg::cmd_t              cmd_i,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [dvru_pkg::NodeW-1:0]       dest_o,
  output logic [dvru_pkg::NodeW-1:0]       index_o,
  output logic [dvru_pkg::CostW-1:0]       cost_o,
  output logic                             last_o
);
  import dvru_pkg::*;

  localparam int unsigned IdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NODE_COUNT - 1);
  localparam logic [IdxW-1:0] PrevIdx = IdxW'(NODE_COUNT - 2);
  localparam logic [NodeW:0]  LastNode = (NodeW + 1)'(NODE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BCAST = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CostW-1:0] link_q [NODE_COUNT];
  logic [CostW-1:0] best_q [NODE_COUNT];
  logic             improved_q, improved_d;
  logic [IdxW-1:0]  dest_q, dest_d;
  logic [IdxW-1:0]  ent_q, ent_d;

  logic             out_valid_q, out_valid_d;
  logic [NodeW-1:0] out_dest_q;
  logic [NodeW-1:0] out_index_q;
  logic [CostW-1:0] out_cost_q;
  logic             out_last_q;

  logic [IdxW-1:0]  rd_addr;
  logic [CostW-1:0] rd_best;
  logic [CostW:0]   cand;
  logic             take;
  logic             better;
  logic             slot_free;
  logic             load_out;
  logic             beat_last;
  logic [IdxW-1:0]  first_dest;
  logic [IdxW-1:0]  last_dest;
  logic [IdxW-1:0]  next_dest;
  logic [NodeW:0]   dest_inc;
  logic [NodeW:0]   self_ext;

  // A command is taken only between broadcasts.
  assign take      = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = take;

  // One read port on the best-cost table, shared by relaxation and broadcast.
  assign rd_addr = (state_q == ST_BCAST) ? ent_q : cmd_i.entry[IdxW-1:0];
  assign rd_best = best_q[rd_addr];

  // Candidate cost through the sending neighbor, one bit wider.
  assign cand   = {1'b0, link_q[cmd_i.src[IdxW-1:0]]} + {1'b0, cmd_i.cost};
  assign better = take && (cmd_i.op == OP_RELAX) && ({1'b0, rd_best} > cand);

  // Destination order skips this node.
  assign self_ext   = {1'b0, cfg_i.self_id};
  assign first_dest = (cfg_i.self_id == '0) ? IdxW'(1) : '0;
  assign last_dest  = (self_ext == LastNode) ? PrevIdx : LastIdx;
  assign dest_inc   = (NodeW + 1)'(dest_q) + 1'b1;
  assign next_dest  = (dest_inc == self_ext) ? IdxW'(dest_inc + 1'b1) : IdxW'(dest_inc);

  assign slot_free = !out_valid_q || out_ready_i;
  assign load_out  = (state_q == ST_BCAST) && slot_free;
  assign beat_last = (ent_q == LastIdx) && (dest_q == last_dest);

  // Sequencer for relaxation and broadcast.
  always_comb begin
    state_d    = state_q;
    improved_d = improved_q;
    dest_d     = dest_q;
    ent_d      = ent_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          improved_d = cmd_i.last ? 1'b0 : (improved_q || better);
          if (cmd_i.last && ((cmd_i.mode == ModeJoin) || improved_q || better)) begin
            state_d = ST_BCAST;
            dest_d  = first_dest;
            ent_d   = '0;
          end
        end
      end
      ST_BCAST: begin
        if (slot_free) begin
          if (ent_q == LastIdx) begin
            ent_d  = '0;
            dest_d = next_dest;
            if (beat_last) begin
              state_d = ST_IDLE;
            end
          end else begin
            ent_d = ent_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      improved_q  <= 1'b0;
      dest_q      <= '0;
      ent_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      improved_q  <= improved_d;
      dest_q      <= dest_d;
      ent_q       <= ent_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Cost tables: a join loads both, a relaxation lowers the best cost.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        link_q[i] <= '0;
        best_q[i] <= '0;
      end
    end else if (take && (cmd_i.op == OP_LOAD)) begin
      link_q[cmd_i.entry[IdxW-1:0]] <= cmd_i.cost;
      best_q[cmd_i.entry[IdxW-1:0]] <= cmd_i.cost;
    end else if (better) begin
      best_q[cmd_i.entry[IdxW-1:0]] <= cand[CostW-1:0];
    end
  end

  // Output register; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_dest_q  <= NodeW'(dest_q);
      out_index_q <= NodeW'(ent_q);
      out_cost_q  <= rd_best;
      out_last_q  <= beat_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dest_o      = out_dest_q;
  assign index_o     = out_index_q;
  assign cost_o      = out_cost_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

FILE: sv/distance_vector_route_update_core.sv
// Channel   Dir  Handshake                    Moves
// s_axis    in   s_axis_tvalid/s_axis_tready  one join or update entry per beat
// m_axis    out  m_axis_tvalid/m_axis_tready  one cost of a broadcast copy per beat
// apb       in   psel/penable, pready high    self_id and unreachable_cost writes
//
// An entry is relaxed or loaded in the back end as it is taken; a two-deep
// command queue lets the front take beats while a broadcast runs.
// A broadcast adds (NODE_COUNT-1)*NODE_COUNT beats, one per cycle while
// m_axis_tready is high, set by the single read port of the best-cost table.
// Reset clears both cost tables and the improved flag at once; no sweep.
// A stalled output holds its beat; input stalls only when the queue is full.
`default_nettype none

module distance_vector_route_update_core #(
  parameter int NODE_COUNT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: source_node[2:0], entry_index[5:3], cost_value[21:6], zero pad
  input  wire logic [23:0] s_axis_tdata,
  // tuser: mode
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: dest_node[2:0], out_index[5:3], out_cost[21:6], zero pad
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import dvru_pkg::*;

  cfg_t             cfg_q;
  cmd_t             front_cmd;
  cmd_t             fifo_cmd;
  logic             push;
  logic             fifo_full;
  logic             fifo_valid;
  logic             pop;
  logic [NodeW-1:0] dest;
  logic [NodeW-1:0] index;
  logic [CostW-1:0] cost;

  // Register writes at the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_id          <= '0;
      cfg_q.unreachable_cost <= 16'd999;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegSelfId:  cfg_q.self_id          <= pwdata[NodeW-1:0];
        RegUnreach: cfg_q.unreachable_cost <= pwdata[CostW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      RegSelfId:  prdata = {{(32 - NodeW){1'b0}}, cfg_q.self_id};
      RegUnreach: prdata = {{(32 - CostW){1'b0}}, cfg_q.unreachable_cost};
      default:    prdata = '0;
    endcase
  end

  dvru_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  dvru_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (fifo_cmd),
    .valid_o (fifo_valid),
    .full_o  (fifo_full)
  );

  dvru_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (fifo_cmd),
    .cmd_valid_i (fifo_valid),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dest_o      (dest),
    .index_o     (index),
    .cost_o      (cost),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, cost, index, dest};

endmodule

`default_nettype wire

FILE: sv/dvru_checker.sv
// Port checker for the distance vector route update core, bound to the top.
// Depends on distance_vector_route_update_core_macros.svh.
`default_nettype none

`include "distance_vector_route_update_core_macros.svh"

module dvru_checker #(
  parameter int NODE_COUNT = 8
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  localparam logic [3:0] NodeCnt = 4'(NODE_COUNT);
  localparam logic [2:0] LastEntry = 3'(NODE_COUNT - 1);

  logic       out_stall;
  logic [2:0] out_dest;
  logic [2:0] out_index;
  logic       dest_ok;
  logic       index_ok;

  // Output fields and their range checks.
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_dest  = m_axis_tdata[2:0];
  assign out_index = m_axis_tdata[5:3];
  assign dest_ok   = {1'b0, out_dest} < NodeCnt;
  assign index_ok  = {1'b0, out_index} < NodeCnt;

  // The configuration port never waits.
  `DVRU_ASSERT(a_pready_high, pready)

  // A stalled output beat stays and keeps its payload.
  `DVRU_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)
  `DVRU_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // A broadcast closes on the final entry of a copy.
  `DVRU_ASSERT(a_last_entry, (m_axis_tvalid && m_axis_tlast) |-> (out_index == LastEntry))

  // Destinations and entries stay within the network.
  `DVRU_ASSERT(a_in_range, m_axis_tvalid |-> (dest_ok && index_ok))

endmodule

bind distance_vector_route_update_core dvru_checker #(.NODE_COUNT(NODE_COUNT)) u_dvru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
